// ===== rtl/md5md_pkg.sv =====
// Shared types, constants and round functions for the MD5 digest block.
`timescale 1ns / 1ps

package md5md_pkg;

    // Item operation codes carried in tuser
    typedef enum logic [1:0] {
        OP_APPEND     = 2'd0,
        OP_APPEND_FIN = 2'd1,
        OP_FINISH     = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    // What follows a compression
    typedef enum logic [1:0] {
        AF_IDLE,
        AF_PAD,
        AF_PAD2,
        AF_OUT
    } t_after;

    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 61;
    localparam int WADDR_W  = 4;
    localparam int LANES    = 4;
    localparam int RND_W    = 6;
    localparam int LEN_POS  = 56;

    localparam logic [7:0]        PAD_MARK = 8'h80;
    localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
    localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
    localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
    localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

    typedef logic [3:0][WORD_W-1:0] t_words;

    // Control from the sequencer to the round datapath
    typedef struct packed {
        logic init;   // chaining words back to the initial values
        logic load;   // working words take the chaining words
        logic round;  // one compression round
        logic fold;   // chaining words accumulate the working words
    } t_core_ctl;

    // Message word used by round i
    function automatic logic [WADDR_W-1:0] msg_index(input logic [RND_W-1:0] i);
        logic [3:0] j;
        logic [WADDR_W-1:0] w;
        j = i[3:0];
        unique case (i[5:4])
            2'd0: w = j;
            2'd1: w = 4'(4'd5 * j + 4'd1);
            2'd2: w = 4'(4'd3 * j + 4'd5);
            2'd3: w = 4'(4'd7 * j);
            default: w = j;
        endcase
        return w;
    endfunction

    // Left rotate amount of round i
    function automatic logic [4:0] rot_amt(input logic [RND_W-1:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    // Additive constant of round i
    function automatic logic [WORD_W-1:0] round_const(input logic [RND_W-1:0] i);
        logic [WORD_W-1:0] k;
        unique case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'hd76aa478;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/md5_message_digest.sv =====
// Top level of the MD5 digest block: item intake, padding and round sequencer.
//
//  channel  | dir | tdata               | tuser            | tlast
//  s_axis   | in  | [7:0] data_byte     | [1:0] operation  | -
//  m_axis   | out | [31:0] digest_word  | [1:0] word_index | last_word
//
// Each append item writes one byte into the block buffer; the 64th byte of a block adds a
// compression (read setup, 64 rounds, fold), with the one-round unit reading one message
// word per cycle from the block buffer.
// Finish writes 1..16 padding words (one per cycle), compresses, and when 8 or fewer
// bytes remain does a second 16-word pass and compression; then 4 items out.
// Reset restores the initial chaining words and a zero byte count; no clearing pass.
// Input is held off while compressing, padding or delivering; output stalls hold the word.
`timescale 1ns / 1ps

module md5_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] digest_word
    output logic [1:0]  o_m_axis_tuser,   // [1:0] word_index
    output logic        o_m_axis_tlast    // last_word
);
    import md5md_pkg::*;

    t_state               r_state, n_state;
    t_after               r_after, n_after;
    logic [COUNT_W-1:0]   r_cnt, n_cnt;
    logic [WADDR_W-1:0]   r_pw, n_pw;
    logic                 r_pass2, n_pass2;
    logic [RND_W-1:0]     r_rnd, n_rnd;
    logic [1:0]           r_oi, n_oi;

    logic [LANES-1:0]     n_we;
    logic [WADDR_W-1:0]   n_waddr, n_raddr;
    logic [WORD_W-1:0]    n_wdata, w_rdata;
    t_core_ctl            n_ctl;
    t_words               w_hash;
    logic                 w_in_acc, w_out_acc;
    logic [COUNT_W-1:0]   w_cnt_inc;
    logic [5:0]           w_used;
    logic [63:0]          w_len_bits;
    logic [5:0]           w_pos;
    t_op                  w_op;

    assign w_op       = t_op'(i_s_axis_tuser);
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc  = o_m_axis_tvalid && i_m_axis_tready;
    assign w_cnt_inc  = r_cnt + 1'b1;
    assign w_used     = r_cnt[5:0];
    assign w_len_bits = {r_cnt, 3'b000};

    md5md_msg_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_raddr (n_raddr),
        .o_rdata (w_rdata)
    );

    md5md_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (n_ctl),
        .i_rnd   (r_rnd),
        .i_msg   (w_rdata),
        .o_hash  (w_hash)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_after <= AF_IDLE;
            r_cnt   <= '0;
            r_pw    <= '0;
            r_pass2 <= 1'b0;
            r_rnd   <= '0;
            r_oi    <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_cnt   <= n_cnt;
            r_pw    <= n_pw;
            r_pass2 <= n_pass2;
            r_rnd   <= n_rnd;
            r_oi    <= n_oi;
        end
    end

    // next state, memory accesses and datapath control
    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_cnt   = r_cnt;
        n_pw    = r_pw;
        n_pass2 = r_pass2;
        n_rnd   = r_rnd;
        n_oi    = r_oi;
        n_we    = '0;
        n_waddr = r_pw;
        n_wdata = '0;
        n_raddr = msg_index('0);
        n_ctl   = '0;
        w_pos   = '0;
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                n_waddr = r_cnt[5:2];
                n_wdata = {LANES{i_s_axis_tdata}};
                if (w_in_acc) begin
                    unique case (w_op)
                        OP_APPEND, OP_APPEND_FIN: begin
                            n_we[r_cnt[1:0]] = 1'b1;
                            n_cnt   = w_cnt_inc;
                            n_pass2 = 1'b0;
                            n_pw    = w_cnt_inc[5:2];
                            if (w_cnt_inc[5:0] == '0) begin
                                n_state = ST_LOAD;
                                n_after = (w_op == OP_APPEND) ? AF_IDLE : AF_PAD;
                            end else if (w_op == OP_APPEND_FIN) begin
                                n_state = ST_PAD;
                            end
                        end
                        OP_FINISH: begin
                            n_pass2 = 1'b0;
                            n_pw    = r_cnt[5:2];
                            n_state = ST_PAD;
                        end
                        OP_NONE: ;
                        default: ;
                    endcase
                end
            end

            // one padding word per cycle: marker, zeros, bit length
            ST_PAD: begin
                for (int l = 0; l < LANES; l++) begin
                    w_pos = {r_pw, 2'(l)};
                    if (r_pass2 || w_pos >= w_used) begin
                        n_we[l] = 1'b1;
                    end
                    if ((r_pass2 || w_used < 6'(LEN_POS)) && w_pos >= 6'(LEN_POS)) begin
                        n_wdata[8*l +: 8] = w_len_bits[8*w_pos[2:0] +: 8];
                    end else if (!r_pass2 && w_pos == w_used) begin
                        n_wdata[8*l +: 8] = PAD_MARK;
                    end
                end
                n_pw = WADDR_W'(r_pw + 1'b1);
                if (r_pw == '1) begin
                    n_state = ST_LOAD;
                    n_after = (!r_pass2 && w_used >= 6'(LEN_POS)) ? AF_PAD2 : AF_OUT;
                end
            end

            // fetch the first round's word, load working words
            ST_LOAD: begin
                n_raddr    = msg_index('0);
                n_ctl.load = 1'b1;
                n_rnd      = '0;
                n_state    = ST_ROUND;
            end

            ST_ROUND: begin
                n_raddr     = msg_index(RND_W'(r_rnd + 1'b1));
                n_ctl.round = 1'b1;
                n_rnd       = RND_W'(r_rnd + 1'b1);
                if (r_rnd == '1) begin
                    n_state = ST_FOLD;
                end
            end

            ST_FOLD: begin
                n_ctl.fold = 1'b1;
                unique case (r_after)
                    AF_IDLE: n_state = ST_IDLE;
                    AF_PAD: begin
                        n_pass2 = 1'b0;
                        n_state = ST_PAD;
                    end
                    AF_PAD2: begin
                        n_pass2 = 1'b1;
                        n_pw    = '0;
                        n_state = ST_PAD;
                    end
                    AF_OUT: begin
                        n_oi    = '0;
                        n_state = ST_OUT;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end

            ST_OUT: begin
                o_m_axis_tvalid = 1'b1;
                if (w_out_acc) begin
                    n_oi = 2'(r_oi + 1'b1);
                    if (r_oi == 2'd3) begin
                        n_ctl.init = 1'b1;
                        n_cnt      = '0;
                        n_state    = ST_IDLE;
                    end
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    assign o_m_axis_tdata = w_hash[r_oi];
    assign o_m_axis_tuser = r_oi;
    assign o_m_axis_tlast = (r_oi == 2'd3);

`ifndef SYNTH
    // intake and delivery never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input and output both active");

    // final digest item restarts the byte count
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_m_axis_tlast) |=> (r_cnt == '0 && r_state == ST_IDLE))
        else $error("count not cleared after digest");

    // the round loop runs its full 64 rounds
    a_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rnd != '1) |=> (r_state == ST_ROUND))
        else $error("round loop left early");

    // the last round is followed by the fold
    a_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rnd == '1) |=> (r_state == ST_FOLD))
        else $error("fold missing after last round");

    // output starts at word a after a fold
    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> (o_m_axis_tuser == 2'd0))
        else $error("digest does not start at word a");
`endif

endmodule

// ===== rtl/md5md_msg_mem.sv =====
// Block buffer: 16 message words with byte-lane writes and a registered read.
`timescale 1ns / 1ps

module md5md_msg_mem (
    input  logic                                i_clk,
    input  logic [md5md_pkg::LANES-1:0]         i_we,
    input  logic [md5md_pkg::WADDR_W-1:0]       i_waddr,
    input  logic [md5md_pkg::WORD_W-1:0]        i_wdata,
    input  logic [md5md_pkg::WADDR_W-1:0]       i_raddr,
    output logic [md5md_pkg::WORD_W-1:0]        o_rdata
);
    import md5md_pkg::*;

    logic [WORD_W-1:0] r_mem [1<<WADDR_W];

    // byte-lane write; lane 0 holds the lowest-addressed byte
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_we[l]) begin
                r_mem[i_waddr][8*l +: 8] <= i_wdata[8*l +: 8];
            end
        end
    end

    // synchronous read into a registered output
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/md5md_core.sv =====
// Chaining words and the one-round-per-cycle MD5 compression datapath.
`timescale 1ns / 1ps

module md5md_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  md5md_pkg::t_core_ctl          i_ctl,
    input  logic [md5md_pkg::RND_W-1:0]   i_rnd,
    input  logic [md5md_pkg::WORD_W-1:0]  i_msg,
    output md5md_pkg::t_words             o_hash
);
    import md5md_pkg::*;

    t_words            r_h;
    logic [WORD_W-1:0] r_a, r_b, r_c, r_d;
    logic [WORD_W-1:0] r_pre;       // a + K of the coming round
    logic [WORD_W-1:0] n_f, n_sum, n_rot;
    logic [2*WORD_W-1:0] n_dbl;

    // round function, sum and rotate
    always_comb begin
        unique case (i_rnd[5:4])
            2'd0: n_f = r_d ^ (r_b & (r_c ^ r_d));
            2'd1: n_f = r_c ^ (r_d & (r_b ^ r_c));
            2'd2: n_f = r_b ^ r_c ^ r_d;
            2'd3: n_f = r_c ^ (r_b | ~r_d);
            default: n_f = '0;
        endcase
        n_sum = r_pre + n_f + i_msg;
        n_dbl = {n_sum, n_sum} << rot_amt(i_rnd);
        n_rot = n_dbl[2*WORD_W-1:WORD_W];
    end

    // chaining words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_h <= {IV_D, IV_C, IV_B, IV_A};
        end else if (i_ctl.fold) begin
            r_h[0] <= r_h[0] + r_a;
            r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d;
        end
    end

    // working words
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a   <= r_h[0];
            r_b   <= r_h[1];
            r_c   <= r_h[2];
            r_d   <= r_h[3];
            r_pre <= r_h[0] + round_const('0);
        end else if (i_ctl.round) begin
            r_a   <= r_d;
            r_b   <= r_b + n_rot;
            r_c   <= r_b;
            r_d   <= r_c;
            r_pre <= r_d + round_const(RND_W'(i_rnd + 1'b1));
        end
    end

    assign o_hash = r_h;

endmodule

// ===== tb/md5_message_digest_tb.sv =====
// Self-checking stream testbench for the MD5 digest block, with a built-in MD5 predictor.
`timescale 1ns / 1ps

module md5_message_digest_tb;

    import md5md_pkg::*;

    // One stream item: operation, message byte, and whether to wait for all digests first
    typedef struct {
        t_op        op;
        logic [7:0] data;
        bit         wait_drain;
    } t_byte_item;

    // One digest word as the block delivers it
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  idx;
        logic        last;
    } t_digest_word;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int CALM_FROM   = 150;
    localparam int CALM_TO     = 260;

    // Per-round additive constants
    localparam logic [31:0] K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Left rotate amounts, four per round group
    localparam int ROT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                    4, 11, 16, 23, 6, 10, 15, 21};

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data  = 8'h00;
    logic [1:0]  s_op    = OP_APPEND;
    logic        m_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    // Predictor state
    logic [31:0] md5_chain [4];
    logic [7:0]  blk_bytes [64];
    logic [60:0] msg_len;

    t_byte_item   stim_q [$];
    t_digest_word digest_q [$];

    int  sent_cnt    = 0;
    int  mismatches  = 0;
    int  gen_items   = 0;
    int  hold_cycles = 0;
    bit  hold_done   = 1'b0;
    logic calm;
    logic rx_hold;

    assign calm    = (sent_cnt >= CALM_FROM) && (sent_cnt < CALM_TO);
    assign rx_hold = (sent_cnt >= HOLD_AT) && !hold_done;

    md5_message_digest dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),    // [7:0] data_byte
        .i_s_axis_tuser  (s_op),      // [1:0] operation
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [31:0] digest_word
        .o_m_axis_tuser  (o_m_axis_tuser),   // [1:0] word_index
        .o_m_axis_tlast  (o_m_axis_tlast)    // last_word
    );

    // Clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Back to the initial chaining words for a new message
    task automatic digest_restart();
        md5_chain[0] = 32'h67452301;
        md5_chain[1] = 32'hefcdab89;
        md5_chain[2] = 32'h98badcfe;
        md5_chain[3] = 32'h10325476;
        foreach (blk_bytes[k]) blk_bytes[k] = 8'h00;
        msg_len = '0;
    endtask

    // 64-round compression of the current block into the chaining words
    task automatic compress_blk();
        logic [31:0] m [16];
        logic [31:0] a, b, c, d, f, sum, tmp;
        int i, g, w, s;
        for (i = 0; i < 16; i++)
            m[i] = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
        a = md5_chain[0];
        b = md5_chain[1];
        c = md5_chain[2];
        d = md5_chain[3];
        for (i = 0; i < 64; i++) begin
            g = i / 16;
            case (g)
                0: begin
                    f = d ^ (b & (c ^ d));
                    w = i;
                end
                1: begin
                    f = c ^ (d & (b ^ c));
                    w = (5 * i + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    w = (3 * i + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    w = (7 * i) % 16;
                end
            endcase
            s   = ROT_TAB[g * 4 + i % 4];
            sum = a + f + m[w] + K_TAB[i];
            tmp = d;
            d   = c;
            c   = b;
            b   = b + ((sum << s) | (sum >> (32 - s)));
            a   = tmp;
        end
        md5_chain[0] = md5_chain[0] + a;
        md5_chain[1] = md5_chain[1] + b;
        md5_chain[2] = md5_chain[2] + c;
        md5_chain[3] = md5_chain[3] + d;
    endtask

    // Apply one accepted item; on finish, pad and queue the four digest words
    task automatic absorb_item(input logic [1:0] op, input logic [7:0] db);
        int used, k;
        logic [63:0] nbits;
        t_digest_word dw;
        if (op == OP_NONE)
            return;
        if (op == OP_APPEND || op == OP_APPEND_FIN) begin
            blk_bytes[msg_len[5:0]] = db;
            msg_len = msg_len + 61'd1;
            if (msg_len[5:0] == 6'd0)
                compress_blk();
        end
        if (op == OP_APPEND)
            return;
        used = msg_len[5:0];
        blk_bytes[used] = PAD_BYTE;
        used++;
        // no room left for the length: pad out and use an extra block
        if (used > 56) begin
            for (k = used; k < 64; k++) blk_bytes[k] = 8'h00;
            compress_blk();
            used = 0;
        end
        for (k = used; k < 56; k++) blk_bytes[k] = 8'h00;
        nbits = {msg_len, 3'b000};
        for (k = 0; k < 8; k++) blk_bytes[56 + k] = nbits[8*k +: 8];
        compress_blk();
        for (k = 0; k < 4; k++) begin
            dw.word = md5_chain[k];
            dw.idx  = k[1:0];
            dw.last = (k == 3);
            digest_q.push_back(dw);
        end
        digest_restart();
    endtask

    task automatic queue_item(input t_op op, input logic [7:0] db, input bit drain);
        t_byte_item it;
        it.op         = op;
        it.data       = db;
        it.wait_drain = drain;
        stim_q.push_back(it);
        if (op != OP_NONE)
            gen_items++;
    endtask

    // One well-formed message of random content, with the odd ignored item mixed in
    task automatic queue_message(input int len, input bit drain);
        int n;
        bit with_byte;
        with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        n = with_byte ? len - 1 : len;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 6)
                queue_item(OP_NONE, 8'($urandom), 1'b0);
            queue_item(OP_APPEND, 8'($urandom), drain && (i == 0));
        end
        if (with_byte)
            queue_item(OP_APPEND_FIN, 8'($urandom), drain && (n == 0));
        else
            queue_item(OP_FINISH, 8'($urandom), drain && (n == 0));
    endtask

    // Receiver hold-off: one long stretch with tready low
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end else if (!hold_done && sent_cnt >= HOLD_AT) begin
            if (hold_cycles == HOLD_CYCLES)
                hold_done <= 1'b1;
            else
                hold_cycles <= hold_cycles + 1;
        end
    end

    // Driver: offer pending items, predict on each accepted one
    always @(posedge i_clk) begin : drv
        t_byte_item nxt;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            s_data  <= 8'h00;
            s_op    <= OP_APPEND;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                absorb_item(s_op, s_data);
                sent_cnt <= sent_cnt + 1;
            end
            if (!s_valid || o_s_axis_tready) begin
                if (stim_q.size() != 0
                    && !(stim_q[0].wait_drain && digest_q.size() != 0)
                    && (calm || $urandom_range(0, 99) >= 34)) begin
                    nxt = stim_q.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= nxt.data;
                    s_op    <= nxt.op;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each delivered digest word with the oldest expected one
    always @(posedge i_clk) begin : mon
        t_digest_word want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                if (digest_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected digest word %h index %0d last %0b",
                                 o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                    mismatches++;
                end else begin
                    want = digest_q.pop_front();
                    if (o_m_axis_tdata !== want.word || o_m_axis_tuser !== want.idx
                        || o_m_axis_tlast !== want.last) begin
                        if (mismatches < 10)
                            $display("digest mismatch: exp %h idx %0d last %0b, got %h idx %0d last %0b",
                                     want.word, want.idx, want.last,
                                     o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            m_ready <= !rx_hold && (calm || $urandom_range(0, 99) >= 34);
        end
    end

    // Stimulus, reset and end of run
    initial begin : stim
        int lens [4];
        int n_msgs;
        int len;
        bit drain;
        digest_restart();

        // empty message, ignored codes, byte extremes
        queue_item(OP_FINISH, 8'hff, 1'b0);
        queue_item(OP_NONE, 8'h00, 1'b0);
        queue_item(OP_NONE, 8'hff, 1'b0);
        queue_item(OP_APPEND_FIN, 8'h00, 1'b0);
        queue_item(OP_APPEND, 8'hff, 1'b0);
        queue_item(OP_NONE, 8'h5a, 1'b0);
        queue_item(OP_APPEND, 8'h00, 1'b0);
        queue_item(OP_APPEND_FIN, 8'hff, 1'b0);
        queue_item(OP_APPEND, PAD_BYTE, 1'b0);
        queue_item(OP_FINISH, 8'h00, 1'b0);
        // empty message right after a full drain
        queue_item(OP_FINISH, 8'h3c, 1'b1);

        // block boundaries: length just fits, spills into an extra block, full block
        lens = '{55, 56, 63, 64};
        foreach (lens[k]) queue_message(lens[k], 1'b0);

        // random messages, mostly short, up to the item budget
        n_msgs = 0;
        while (gen_items < 260 || n_msgs < 2) begin
            if ($urandom_range(0, 99) < 5)
                len = $urandom_range(40, 70);
            else
                len = $urandom_range(0, 12);
            drain = (n_msgs == 0) || ($urandom_range(0, 99) < 10);
            queue_message(len, drain);
            n_msgs++;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || s_valid) @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (mismatches == 0 && digest_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
